// ===== rtl/core/iorp_pkg.sv =====
// Shared types and constants of the ready-set priority picker.
`default_nettype none
package iorp_pkg;

   localparam int NET_QUEUES    = 8;
   localparam int BLOCK_DEVICES = 4;
   localparam int BLOCK_TOKENS  = 32;

   localparam int INDEX_W   = 6;
   localparam int BLOCK_W   = 4;
   localparam int CELL_BITS = (NET_QUEUES > BLOCK_TOKENS) ? NET_QUEUES : BLOCK_TOKENS;
   localparam int NUM_CELLS = BLOCK_DEVICES + 1;
   localparam int CELL_ID_W = $clog2(NUM_CELLS);

   typedef enum logic [2:0] {
      REQ_NET_SET   = 3'd0,
      REQ_NET_CLR   = 3'd1,
      REQ_BLK_SET   = 3'd2,
      REQ_BLK_CLR   = 3'd3,
      REQ_WAIT      = 3'd4,
      REQ_TICK      = 3'd5,
      REQ_NET_QUERY = 3'd6
   } req_kind_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_NET   = 2'd1,
      KIND_BLOCK = 2'd2,
      KIND_QUERY = 2'd3
   } rsp_kind_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EVAL = 1'b1
   } state_type;

   // Bit update or probe sent to every cell of the chain
   typedef struct packed {
      logic                 set;
      logic                 clr;
      logic [CELL_ID_W-1:0] cell_num;
      logic [INDEX_W-1:0]   bit_index;
   } cell_cmd_type;

   // Lowest ready bit seen from a cell toward the end of the chain
   typedef struct packed {
      logic                 found;
      logic [CELL_ID_W-1:0] cell_num;
      logic [INDEX_W-1:0]   bit_index;
   } pick_type;

endpackage
`default_nettype wire

// ===== rtl/core/iorp_cell.sv =====
// One bitmap cell of the priority chain: holds a ready word and merges its pick.
`default_nettype none
module iorp_cell (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [iorp_pkg::CELL_ID_W-1:0] cell_id,
   input  wire iorp_pkg::cell_cmd_type         cmd,
   input  wire iorp_pkg::pick_type             pick_in,
   output iorp_pkg::pick_type                  pick_out,
   output logic                                probe_bit
);

   logic [iorp_pkg::CELL_BITS-1:0] bits_ff;
   logic [iorp_pkg::CELL_BITS-1:0] bits_in;
   logic [iorp_pkg::CELL_BITS-1:0] hit;
   logic [iorp_pkg::INDEX_W-1:0]   low;
   logic                           mine;

   always_comb begin
      for (int j = 0; j < iorp_pkg::CELL_BITS; j++) begin
         hit[j] = (cmd.bit_index == iorp_pkg::INDEX_W'(j));
      end
   end

   assign mine      = (cmd.cell_num == cell_id);
   assign probe_bit = |(bits_ff & hit);

   always_comb begin
      bits_in = bits_ff;
      if (mine && cmd.set) begin
         bits_in = bits_ff | hit;
      end else if (mine && cmd.clr) begin
         bits_in = bits_ff & ~hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= '0;
      end else begin
         bits_ff <= bits_in;
      end
   end

   // Lowest set bit of this word
   always_comb begin
      low = '0;
      for (int j = iorp_pkg::CELL_BITS - 1; j >= 0; j--) begin
         if (bits_ff[j]) begin
            low = iorp_pkg::INDEX_W'(j);
         end
      end
   end

   // Own word wins over everything further down the chain
   always_comb begin
      if (|bits_ff) begin
         pick_out.found     = 1'b1;
         pick_out.cell_num  = cell_id;
         pick_out.bit_index = low;
      end else begin
         pick_out = pick_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/io_ready_set_priority_picker.sv =====
// Top level of the ready-set priority picker: request decode, wait timer and result register.
//
// Usage: requests enter on the req_ stream; each one sets, clears or queries a ready
// bit, starts a wait or delivers a tick. A result, if the request causes one, leaves
// on the rsp_ stream. Bitmaps live in a chain of cells: cell 0 holds the network
// queues, cell k+1 block device k. Each cell offers its lowest ready bit and passes
// it on when it has none, so the head of the chain gives the fixed-priority pick.
// Steps: a request is taken in ST_IDLE, which also updates the target cell, and
// ST_EVAL then reads the chain head and loads the result register; no new request
// is taken until ST_EVAL ends. The chain read is the only step after the update,
// for any request mix.
// While a result waits in the output register the next request is still taken; the
// evaluation cycle then holds until rsp_tready frees the register.
// Reset clears all bitmaps, ends any pending wait and drops a waiting result.
`default_nettype none
module io_ready_set_priority_picker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [2:0] req_type, [8:3] net_index, [12:9] block_index, [18:13] token_index,
   // [50:19] wait_ticks, [55:51] zero
   input  wire logic [55:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [1:0] result_kind, [7:2] picked_net, [11:8] picked_block, [17:12] picked_token,
   // [18] net_is_ready, [23:19] zero
   output logic [23:0]      rsp_tdata
);

   localparam int IW = iorp_pkg::INDEX_W;
   localparam int BW = iorp_pkg::BLOCK_W;
   localparam int CW = iorp_pkg::CELL_ID_W;

   iorp_pkg::state_type    state_ff, state_in;
   logic [2:0]             type_ff;
   logic [IW-1:0]          net_ff;
   logic [31:0]            wait_ff;
   logic                   ok_ff, ok_in;
   logic                   waiting_ff, waiting_in;
   logic [31:0]            ticks_ff, ticks_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   iorp_pkg::rsp_kind_type kind_ff, kind_in;
   logic [IW-1:0]          pnet_ff, pnet_in;
   logic [BW-1:0]          pblk_ff, pblk_in;
   logic [IW-1:0]          ptok_ff, ptok_in;
   logic                   prdy_ff, prdy_in;

   logic [2:0]             req_type;
   logic [IW-1:0]          req_net;
   logic [BW-1:0]          req_block;
   logic [IW-1:0]          req_token;
   logic                   accept;
   logic                   net_ok;
   logic                   blk_ok;
   logic                   out_free;
   logic [31:0]            ticks_dec;

   iorp_pkg::cell_cmd_type cmd;
   iorp_pkg::pick_type     chain [iorp_pkg::NUM_CELLS+1];
   logic [iorp_pkg::NUM_CELLS-1:0] probe;

   assign req_type  = req_tdata[2:0];
   assign req_net   = req_tdata[8:3];
   assign req_block = req_tdata[12:9];
   assign req_token = req_tdata[18:13];

   assign req_tready = (state_ff == iorp_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign net_ok = req_net < IW'(iorp_pkg::NET_QUEUES);
   assign blk_ok = ({1'b0, req_block} < (BW+1)'(iorp_pkg::BLOCK_DEVICES))
                   && (req_token < IW'(iorp_pkg::BLOCK_TOKENS));

   // Drive the cell update on acceptance; probe with the held index afterwards
   always_comb begin
      cmd = '0;
      ok_in = ok_ff;
      if (state_ff == iorp_pkg::ST_IDLE) begin
         case (iorp_pkg::req_kind_type'(req_type))
            iorp_pkg::REQ_NET_SET, iorp_pkg::REQ_NET_CLR, iorp_pkg::REQ_NET_QUERY: begin
               ok_in         = net_ok;
               cmd.cell_num  = '0;
               cmd.bit_index = req_net;
            end
            iorp_pkg::REQ_BLK_SET, iorp_pkg::REQ_BLK_CLR: begin
               ok_in         = blk_ok;
               cmd.cell_num  = CW'(req_block) + CW'(1);
               cmd.bit_index = req_token;
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
         cmd.set = accept && ok_in && ((req_type == iorp_pkg::REQ_NET_SET)
                                       || (req_type == iorp_pkg::REQ_BLK_SET));
         cmd.clr = accept && ok_in && ((req_type == iorp_pkg::REQ_NET_CLR)
                                       || (req_type == iorp_pkg::REQ_BLK_CLR));
         if (!accept) begin
            ok_in = ok_ff;
         end
      end else begin
         cmd.cell_num  = '0;
         cmd.bit_index = net_ff;
      end
   end

   assign chain[iorp_pkg::NUM_CELLS] = '0;

   for (genvar k = 0; k < iorp_pkg::NUM_CELLS; k++) begin : g_cell
      iorp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_id   (CW'(k)),
         .cmd       (cmd),
         .pick_in   (chain[k+1]),
         .pick_out  (chain[k]),
         .probe_bit (probe[k])
      );
   end

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign ticks_dec = (ticks_ff != 32'd0) ? (ticks_ff - 32'd1) : 32'd0;

   always_comb begin
      state_in     = state_ff;
      waiting_in   = waiting_ff;
      ticks_in     = ticks_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      kind_in      = kind_ff;
      pnet_in      = pnet_ff;
      pblk_in      = pblk_ff;
      ptok_in      = ptok_ff;
      prdy_in      = prdy_ff;

      if (state_ff == iorp_pkg::ST_IDLE) begin
         if (accept) begin
            state_in = iorp_pkg::ST_EVAL;
         end
      end else if (out_free) begin
         state_in = iorp_pkg::ST_IDLE;
         kind_in  = iorp_pkg::KIND_NONE;
         pnet_in  = '0;
         pblk_in  = '0;
         ptok_in  = '0;
         prdy_in  = 1'b0;
         case (iorp_pkg::req_kind_type'(type_ff))
            iorp_pkg::REQ_NET_SET, iorp_pkg::REQ_BLK_SET, iorp_pkg::REQ_WAIT: begin
               if (chain[0].found && (ok_ff || (type_ff == iorp_pkg::REQ_WAIT))
                   && (waiting_ff || (type_ff == iorp_pkg::REQ_WAIT))) begin
                  rsp_valid_in = 1'b1;
                  waiting_in   = 1'b0;
                  ticks_in     = '0;
                  if (chain[0].cell_num == '0) begin
                     kind_in = iorp_pkg::KIND_NET;
                     pnet_in = chain[0].bit_index;
                  end else begin
                     kind_in = iorp_pkg::KIND_BLOCK;
                     pblk_in = BW'(chain[0].cell_num - CW'(1));
                     ptok_in = chain[0].bit_index;
                  end
               end else if (type_ff == iorp_pkg::REQ_WAIT) begin
                  if (wait_ff == 32'd0) begin
                     rsp_valid_in = 1'b1;
                     waiting_in   = 1'b0;
                     ticks_in     = '0;
                  end else begin
                     waiting_in = 1'b1;
                     ticks_in   = wait_ff;
                  end
               end
            end
            iorp_pkg::REQ_TICK: begin
               if (waiting_ff) begin
                  ticks_in = ticks_dec;
                  if (ticks_dec == 32'd0) begin
                     rsp_valid_in = 1'b1;
                     waiting_in   = 1'b0;
                  end
               end
            end
            iorp_pkg::REQ_NET_QUERY: begin
               rsp_valid_in = 1'b1;
               kind_in      = iorp_pkg::KIND_QUERY;
               prdy_in      = ok_ff && probe[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iorp_pkg::ST_IDLE;
         waiting_ff   <= 1'b0;
         ticks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         waiting_ff   <= waiting_in;
         ticks_ff     <= ticks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the request fields for the evaluation cycle
   always_ff @(posedge clock) begin
      ok_ff   <= ok_in;
      kind_ff <= kind_in;
      pnet_ff <= pnet_in;
      pblk_ff <= pblk_in;
      ptok_ff <= ptok_in;
      prdy_ff <= prdy_in;
      if (accept) begin
         type_ff <= req_type;
         net_ff  <= req_net;
         wait_ff <= req_tdata[50:19];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, prdy_ff, ptok_ff, pblk_ff, pnet_ff, kind_ff};

`ifndef NO_ASSERTIONS
   a_wait_has_ticks: assert property (@(posedge clock) disable iff (reset)
      waiting_ff |-> (ticks_ff != 32'd0))
      else $error("pending wait with no ticks left");

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == iorp_pkg::ST_EVAL))
      else $error("accepted transaction not evaluated");

   a_wait_nothing_ready: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == iorp_pkg::ST_IDLE) && waiting_ff) |-> !chain[0].found)
      else $error("wait pending while a ready bit is set");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_io_ready_set_priority_picker.sv =====
// Testbench for the ready-set priority picker: directed and random requests checked against a predictor.
`timescale 1ns / 100ps
module tb_io_ready_set_priority_picker;

   localparam logic [2:0] REQ_UNUSED = 3'd7;

   // Packed like req_tdata[50:0], last field in the lowest bits
   typedef struct packed {
      logic [31:0] ticks;
      logic [5:0]  token;
      logic [3:0]  block;
      logic [5:0]  net;
      logic [2:0]  code;
   } req_item_type;

   // Packed like rsp_tdata[18:0]
   typedef struct packed {
      logic        rdy;
      logic [5:0]  token;
      logic [3:0]  block;
      logic [5:0]  net;
      logic [1:0]  kind;
   } answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   // Predicted block state
   logic [iorp_pkg::NET_QUEUES-1:0]   net_ready;
   logic [iorp_pkg::BLOCK_TOKENS-1:0] blk_ready [iorp_pkg::BLOCK_DEVICES];
   logic                              wait_pending;
   logic [31:0]                       wait_ticks_left;

   answer_type answers_due[$];
   int         bad_answers = 0;
   bit         gaps_on = 1'b1;
   int         stall_left = 0;

   io_ready_set_priority_picker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   initial begin
      #1_600_000;
      $display("== FAIL ==");
      $finish;
   end

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (!gaps_on || roll < 55) return 0;
      if (roll < 90) return $urandom_range(3, 1);
      if (roll < 98) return $urandom_range(10, 4);
      return $urandom_range(40, 20);
   endfunction

   function automatic req_item_type make_req(input logic [2:0] code, input int net,
                                             input int block, input int token,
                                             input logic [31:0] ticks);
      req_item_type r;
      r.code  = code;
      r.net   = 6'(net);
      r.block = 4'(block);
      r.token = 6'(token);
      r.ticks = ticks;
      return r;
   endfunction

   // Fixed-priority pick over the predicted bitmaps
   function automatic bit lowest_ready(output answer_type a);
      a = '0;
      for (int i = 0; i < iorp_pkg::NET_QUEUES; i++) begin
         if (net_ready[i]) begin
            a.kind = iorp_pkg::KIND_NET;
            a.net  = 6'(i);
            return 1'b1;
         end
      end
      for (int b = 0; b < iorp_pkg::BLOCK_DEVICES; b++) begin
         for (int t = 0; t < iorp_pkg::BLOCK_TOKENS; t++) begin
            if (blk_ready[b][t]) begin
               a.kind  = iorp_pkg::KIND_BLOCK;
               a.block = 4'(b);
               a.token = 6'(t);
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   // Advance the predicted state by one request; return 1 when it yields an answer
   function automatic bit apply_request(input req_item_type r, output answer_type a);
      bit net_ok;
      bit blk_ok;
      net_ok = r.net < iorp_pkg::NET_QUEUES;
      blk_ok = r.block < iorp_pkg::BLOCK_DEVICES && r.token < iorp_pkg::BLOCK_TOKENS;
      a = '0;
      case (r.code)
         iorp_pkg::REQ_NET_SET, iorp_pkg::REQ_BLK_SET: begin
            if (r.code == iorp_pkg::REQ_NET_SET) begin
               if (!net_ok) return 1'b0;
               net_ready[r.net] = 1'b1;
            end else begin
               if (!blk_ok) return 1'b0;
               blk_ready[r.block][r.token] = 1'b1;
            end
            if (wait_pending && lowest_ready(a)) begin
               wait_pending    = 1'b0;
               wait_ticks_left = '0;
               return 1'b1;
            end
            return 1'b0;
         end
         iorp_pkg::REQ_NET_CLR: begin
            if (net_ok) net_ready[r.net] = 1'b0;
            return 1'b0;
         end
         iorp_pkg::REQ_BLK_CLR: begin
            if (blk_ok) blk_ready[r.block][r.token] = 1'b0;
            return 1'b0;
         end
         iorp_pkg::REQ_WAIT: begin
            wait_pending    = 1'b0;
            wait_ticks_left = '0;
            if (lowest_ready(a)) return 1'b1;
            if (r.ticks == 0) begin
               a.kind = iorp_pkg::KIND_NONE;
               return 1'b1;
            end
            wait_pending    = 1'b1;
            wait_ticks_left = r.ticks;
            return 1'b0;
         end
         iorp_pkg::REQ_TICK: begin
            if (!wait_pending) return 1'b0;
            if (wait_ticks_left > 0) wait_ticks_left = wait_ticks_left - 32'd1;
            if (wait_ticks_left == 0) begin
               wait_pending = 1'b0;
               a.kind       = iorp_pkg::KIND_NONE;
               return 1'b1;
            end
            return 1'b0;
         end
         iorp_pkg::REQ_NET_QUERY: begin
            a.kind = iorp_pkg::KIND_QUERY;
            a.rdy  = net_ok ? net_ready[r.net] : 1'b0;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // Drive one request and hold it until the picker accepts it
   task automatic send_req(input req_item_type r);
      int         gap;
      answer_type a;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, r};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (apply_request(r, a)) answers_due.push_back(a);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         bad_answers++;
      end
   endtask

   always @(posedge clock) begin : answer_check
      answer_type want;
      answer_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[18:0];
         if (answers_due.size() == 0) begin
            $display("%0t: unexpected answer, expected none, actual %h", $time, rsp_tdata);
            bad_answers++;
         end else begin
            want = answers_due.pop_front();
            check_field("result_kind", want.kind, got.kind);
            check_field("picked_net", want.net, got.net);
            check_field("picked_block", want.block, got.block);
            check_field("picked_token", want.token, got.token);
            check_field("net_is_ready", want.rdy, got.rdy);
         end
      end
   end

   // Random receiver stalls
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= pick_gap();
      end
   end

   task automatic test_net_bits();
      send_req(make_req(iorp_pkg::REQ_NET_QUERY, 0, 0, 0, 0));
      send_req(make_req(iorp_pkg::REQ_NET_SET, iorp_pkg::NET_QUEUES - 1, 0, 0, 0));
      send_req(make_req(iorp_pkg::REQ_NET_QUERY, iorp_pkg::NET_QUEUES - 1, 0, 0, 0));
      send_req(make_req(iorp_pkg::REQ_NET_SET, iorp_pkg::NET_QUEUES, 0, 0, 0));
      send_req(make_req(iorp_pkg::REQ_NET_QUERY, iorp_pkg::NET_QUEUES, 0, 0, 0));
      send_req(make_req(iorp_pkg::REQ_NET_QUERY, 62, 15, 62, 32'hFFFF_FFFF));
      send_req(make_req(iorp_pkg::REQ_NET_CLR, 62, 0, 0, 0));
      send_req(make_req(iorp_pkg::REQ_NET_CLR, iorp_pkg::NET_QUEUES - 1, 0, 0, 0));
      send_req(make_req(iorp_pkg::REQ_NET_QUERY, iorp_pkg::NET_QUEUES - 1, 0, 0, 0));
   endtask

   task automatic test_wait_timeout();
      send_req(make_req(iorp_pkg::REQ_WAIT, 0, 0, 0, 0));
      send_req(make_req(iorp_pkg::REQ_TICK, 0, 0, 0, 0));
      send_req(make_req(iorp_pkg::REQ_WAIT, 0, 0, 0, 3));
      send_req(make_req(iorp_pkg::REQ_TICK, 0, 0, 0, 0));
      send_req(make_req(iorp_pkg::REQ_NET_QUERY, 3, 0, 0, 0));
      send_req(make_req(iorp_pkg::REQ_NET_CLR, 3, 0, 0, 0));
      send_req(make_req(iorp_pkg::REQ_TICK, 0, 0, 0, 0));
      send_req(make_req(iorp_pkg::REQ_TICK, 0, 0, 0, 0));
      send_req(make_req(REQ_UNUSED, 63, 15, 63, 32'hFFFF_FFFF));
   endtask

   task automatic test_wait_answered();
      send_req(make_req(iorp_pkg::REQ_WAIT, 0, 0, 0, 5));
      send_req(make_req(iorp_pkg::REQ_BLK_SET, 0, iorp_pkg::BLOCK_DEVICES - 1,
                        iorp_pkg::BLOCK_TOKENS - 1, 0));
      send_req(make_req(iorp_pkg::REQ_WAIT, 0, 0, 0, 32'hFFFF_FFFF));
      send_req(make_req(iorp_pkg::REQ_NET_SET, 5, 0, 0, 0));
      send_req(make_req(iorp_pkg::REQ_WAIT, 0, 0, 0, 1));
      send_req(make_req(iorp_pkg::REQ_NET_CLR, 5, 0, 0, 0));
      send_req(make_req(iorp_pkg::REQ_BLK_CLR, 0, iorp_pkg::BLOCK_DEVICES - 1,
                        iorp_pkg::BLOCK_TOKENS - 1, 0));
      // A second wait replaces the first one and its timeout
      send_req(make_req(iorp_pkg::REQ_WAIT, 0, 0, 0, 2));
      send_req(make_req(iorp_pkg::REQ_WAIT, 0, 0, 0, 1));
      send_req(make_req(iorp_pkg::REQ_BLK_SET, 0, iorp_pkg::BLOCK_DEVICES, 0, 0));
      send_req(make_req(iorp_pkg::REQ_BLK_SET, 0, 0, iorp_pkg::BLOCK_TOKENS, 0));
      send_req(make_req(iorp_pkg::REQ_BLK_SET, 0, 15, 62, 0));
      send_req(make_req(iorp_pkg::REQ_TICK, 0, 0, 0, 0));
      send_req(make_req(iorp_pkg::REQ_BLK_SET, 0, 0, 0, 0));
      send_req(make_req(iorp_pkg::REQ_BLK_SET, 0, 2, 4, 0));
      send_req(make_req(iorp_pkg::REQ_WAIT, 0, 0, 0, 0));
   endtask

   function automatic req_item_type random_req();
      req_item_type r;
      int unsigned  roll;
      roll    = $urandom_range(99);
      r.net   = ($urandom_range(9) == 0) ? 6'($urandom_range(62))
                                         : 6'($urandom_range(iorp_pkg::NET_QUEUES - 1));
      r.block = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                         : 4'($urandom_range(iorp_pkg::BLOCK_DEVICES - 1));
      r.token = ($urandom_range(9) == 0) ? 6'($urandom_range(62))
              : ($urandom_range(1) ? 6'($urandom_range(7))
                                   : 6'($urandom_range(iorp_pkg::BLOCK_TOKENS - 1)));
      r.ticks = ($urandom_range(19) == 0) ? $urandom() : $urandom_range(4);
      if (roll < 10) r.code = iorp_pkg::REQ_NET_SET;
      else if (roll < 25) r.code = iorp_pkg::REQ_NET_CLR;
      else if (roll < 35) r.code = iorp_pkg::REQ_BLK_SET;
      else if (roll < 52) r.code = iorp_pkg::REQ_BLK_CLR;
      else if (roll < 67) r.code = iorp_pkg::REQ_WAIT;
      else if (roll < 87) r.code = iorp_pkg::REQ_TICK;
      else if (roll < 98) r.code = iorp_pkg::REQ_NET_QUERY;
      else r.code = REQ_UNUSED;
      return r;
   endfunction

   // Drop every ready bit so that the next waits can time out
   task automatic clear_all_ready();
      for (int i = 0; i < iorp_pkg::NET_QUEUES; i++)
         if (net_ready[i]) send_req(make_req(iorp_pkg::REQ_NET_CLR, i, 0, 0, 0));
      for (int b = 0; b < iorp_pkg::BLOCK_DEVICES; b++)
         for (int t = 0; t < iorp_pkg::BLOCK_TOKENS; t++)
            if (blk_ready[b][t]) send_req(make_req(iorp_pkg::REQ_BLK_CLR, 0, b, t, 0));
   endtask

   task automatic test_random(input int count);
      int sent;
      sent = 0;
      while (sent < count) begin
         gaps_on = ($urandom_range(3) != 0);
         clear_all_ready();
         repeat (40) begin
            send_req(random_req());
            sent++;
         end
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      net_ready       = '0;
      wait_pending    = 1'b0;
      wait_ticks_left = '0;
      for (int b = 0; b < iorp_pkg::BLOCK_DEVICES; b++) blk_ready[b] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_net_bits();
      test_wait_timeout();
      test_wait_answered();
      test_random(1750);
      req_tvalid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      // Leave room for a stray answer behind the longest receiver stall
      repeat (100) @(posedge clock);
      if (bad_answers == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
